/* sv/ddm_pkg.sv */
// shared types and constants for the differential drive mixer
package ddm_pkg;

  localparam int CMD_W = 16;
  localparam int THR_W = 11;
  localparam int SPEED_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 11'd16;

  typedef enum logic [2:0] {
    REQ_DRIVE        = 3'd0,
    REQ_FORWARD      = 3'd1,
    REQ_BACKWARD     = 3'd2,
    REQ_ROTATE_LEFT  = 3'd3,
    REQ_ROTATE_RIGHT = 3'd4,
    REQ_STOP         = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    MC_STOPPED      = 3'd0,
    MC_FORWARD      = 3'd1,
    MC_BACKWARD     = 3'd2,
    MC_ROTATE_LEFT  = 3'd3,
    MC_ROTATE_RIGHT = 3'd4,
    MC_CURVE        = 3'd5
  } motion_t;

  typedef struct packed {
    logic    valid;
    logic    left_neg;
    logic    right_neg;
    motion_t cls;
  } ctl_t;

endpackage

/* sv/ddm_front.sv */
// request decode, clamping, classification and left/right mixing
module ddm_front import ddm_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int LW = 17,
  parameter int DW = 18
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  logic [2:0]              req_type,
  input  logic signed [CMD_W-1:0] linear_cmd,
  input  logic signed [CMD_W-1:0] angular_cmd,
  input  logic [THR_W-1:0]        thr,
  output ctl_t                    ctl_out,
  output logic [DW-1:0]           x_left,
  output logic [DW-1:0]           x_right,
  output logic [DW-1:0]           div
);

  localparam logic signed [LW-1:0] ONE = LW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;

  logic signed [LW-1:0] lc, ac, lc_mag, lin_raw, ang_raw, lin_c, ang_c;
  logic [LW-1:0] lin_m, ang_m;
  logic has_lin, has_ang;
  motion_t cls;

  logic s1_valid;
  logic signed [LW-1:0] s1_lin, s1_ang;
  motion_t s1_cls;

  logic signed [LW:0] left, right;
  logic [DW-1:0] left_m, right_m, m;

  // stage 1: decode, clamp and classify
  always_comb begin
    lc = LW'(linear_cmd);
    ac = LW'(angular_cmd);
    lc_mag = lc[LW-1] ? -lc : lc;
    lin_raw = '0;
    ang_raw = '0;
    case (req_t'(req_type))
      REQ_DRIVE: begin
        lin_raw = lc;
        ang_raw = ac;
      end
      REQ_FORWARD:      lin_raw = lc_mag;
      REQ_BACKWARD:     lin_raw = -lc_mag;
      REQ_ROTATE_LEFT:  ang_raw = -lc_mag;
      REQ_ROTATE_RIGHT: ang_raw = lc_mag;
      default: begin
        lin_raw = '0;
        ang_raw = '0;
      end
    endcase
    lin_c = (lin_raw > ONE) ? ONE : ((lin_raw < -ONE) ? -ONE : lin_raw);
    ang_c = (ang_raw > ONE) ? ONE : ((ang_raw < -ONE) ? -ONE : ang_raw);
    lin_m = lin_c[LW-1] ? LW'(-lin_c) : LW'(lin_c);
    ang_m = ang_c[LW-1] ? LW'(-ang_c) : LW'(ang_c);
    has_lin = lin_m > LW'(thr);
    has_ang = ang_m > LW'(thr);
    if (!has_lin && !has_ang) begin
      cls = MC_STOPPED;
    end else if (has_lin && has_ang) begin
      cls = MC_CURVE;
    end else if (has_lin) begin
      cls = lin_c[LW-1] ? MC_BACKWARD : MC_FORWARD;
    end else begin
      cls = ang_c[LW-1] ? MC_ROTATE_LEFT : MC_ROTATE_RIGHT;
    end
  end

  // stage 2: mix and pick the divisor, one when no scaling is needed
  always_comb begin
    left = (LW+1)'(s1_lin) + (LW+1)'(s1_ang);
    right = (LW+1)'(s1_lin) - (LW+1)'(s1_ang);
    left_m = left[LW] ? DW'(-left) : DW'(left);
    right_m = right[LW] ? DW'(-right) : DW'(right);
    m = (left_m > right_m) ? left_m : right_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      ctl_out.valid <= s1_valid;
    end
    if (advance) begin
      s1_lin <= lin_c;
      s1_ang <= ang_c;
      s1_cls <= cls;
      ctl_out.left_neg <= left[LW];
      ctl_out.right_neg <= right[LW];
      ctl_out.cls <= s1_cls;
      x_left <= left_m;
      x_right <= right_m;
      div <= (m > ONE_D) ? m : ONE_D;
    end
  end

endmodule

/* sv/ddm_cell.sv */
// one restoring division step for both wheels
module ddm_cell import ddm_pkg::*; #(
  parameter int DW = 18,
  parameter int QW = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  ctl_t          ctl_in,
  input  logic [DW:0]   rem_l_in,
  input  logic [DW:0]   rem_r_in,
  input  logic [DW-1:0] div_in,
  input  logic [QW-1:0] q_l_in,
  input  logic [QW-1:0] q_r_in,
  output ctl_t          ctl_out,
  output logic [DW:0]   rem_l_out,
  output logic [DW:0]   rem_r_out,
  output logic [DW-1:0] div_out,
  output logic [QW-1:0] q_l_out,
  output logic [QW-1:0] q_r_out
);

  logic [DW:0] d_ext, diff_l, diff_r;
  logic bit_l, bit_r;

  always_comb begin
    d_ext = {1'b0, div_in};
    bit_l = rem_l_in >= d_ext;
    bit_r = rem_r_in >= d_ext;
    diff_l = bit_l ? (rem_l_in - d_ext) : rem_l_in;
    diff_r = bit_r ? (rem_r_in - d_ext) : rem_r_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (advance) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (advance) begin
      ctl_out.left_neg <= ctl_in.left_neg;
      ctl_out.right_neg <= ctl_in.right_neg;
      ctl_out.cls <= ctl_in.cls;
      // remainder stays below the divisor, so doubling fits
      rem_l_out <= {diff_l[DW-1:0], 1'b0};
      rem_r_out <= {diff_r[DW-1:0], 1'b0};
      div_out <= div_in;
      q_l_out <= {q_l_in[QW-2:0], bit_l};
      q_r_out <= {q_r_in[QW-2:0], bit_r};
    end
  end

endmodule

/* sv/differential_drive_mixer.sv */
// differential drive mixer top level: front stages, divider cell row, output skid
// Arcade mixing of a linear and an angular command into left and right wheel
// speeds in fixed point (ONE = 2**FRAC_BITS), plus a motion class.
// Input channel: in_valid/in_ready with req_type, linear_cmd, angular_cmd.
// Output channel: out_valid/out_ready with left_speed, right_speed,
// motion_class. Config channel: cfg_valid/cfg_ready with cfg_data, which
// sets still_threshold; cfg_ready is always high.
// Pipeline: two front stages, FRAC_BITS + 1 divider cells and one output
// register. Throughput is one beat per cycle while the skid register is empty.
// The speed scaling runs through a row of FRAC_BITS + 1 cells, each
// producing one quotient bit per wheel; that row sets the latency.
// Reset clears all valid bits and loads still_threshold with 16.
// When the receiver stalls, the output register holds its beat and one more
// beat lands in a skid register; in_ready then drops and the whole pipeline
// holds until the skid register drains.
module differential_drive_mixer import ddm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                req_type,
  input  logic signed [CMD_W-1:0]   linear_cmd,
  input  logic signed [CMD_W-1:0]   angular_cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SPEED_W-1:0] left_speed,
  output logic signed [SPEED_W-1:0] right_speed,
  output logic [2:0]                motion_class,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [THR_W-1:0]          cfg_data
);

  localparam int LW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
  localparam int DW = LW + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int NCELL = FRAC_BITS + 1;
  localparam int OW = (FRAC_BITS + 2 > SPEED_W) ? FRAC_BITS + 2 : SPEED_W;
  localparam logic [QW-1:0] Q_ONE = QW'(1) << FRAC_BITS;

  logic [THR_W-1:0] still_threshold;
  logic advance;

  ctl_t        ctl_c   [NCELL+1];
  logic [DW:0]   rem_l_c [NCELL+1];
  logic [DW:0]   rem_r_c [NCELL+1];
  logic [DW-1:0] div_c   [NCELL+1];
  logic [QW-1:0] q_l_c   [NCELL+1];
  logic [QW-1:0] q_r_c   [NCELL+1];
  logic [DW-1:0] x_left, x_right;

  logic push;
  logic signed [OW-1:0] q_l_s, q_r_s, sp_l, sp_r;
  logic skid_valid;
  logic signed [SPEED_W-1:0] skid_left, skid_right;
  logic [2:0] skid_cls;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      still_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      still_threshold <= cfg_data;
    end
  end

  // the pipeline moves whenever the skid register is free
  assign advance = !skid_valid;
  assign in_ready = advance;

  ddm_front #(
    .FRAC_BITS(FRAC_BITS),
    .LW(LW),
    .DW(DW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(in_valid),
    .req_type(req_type),
    .linear_cmd(linear_cmd),
    .angular_cmd(angular_cmd),
    .thr(still_threshold),
    .ctl_out(ctl_c[0]),
    .x_left(x_left),
    .x_right(x_right),
    .div(div_c[0])
  );

  assign rem_l_c[0] = {1'b0, x_left};
  assign rem_r_c[0] = {1'b0, x_right};
  assign q_l_c[0] = '0;
  assign q_r_c[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ddm_cell #(
      .DW(DW),
      .QW(QW)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .advance(advance),
      .ctl_in(ctl_c[i]),
      .rem_l_in(rem_l_c[i]),
      .rem_r_in(rem_r_c[i]),
      .div_in(div_c[i]),
      .q_l_in(q_l_c[i]),
      .q_r_in(q_r_c[i]),
      .ctl_out(ctl_c[i+1]),
      .rem_l_out(rem_l_c[i+1]),
      .rem_r_out(rem_r_c[i+1]),
      .div_out(div_c[i+1]),
      .q_l_out(q_l_c[i+1]),
      .q_r_out(q_r_c[i+1])
    );
  end

  // restore the sign, truncating toward zero
  always_comb begin
    q_l_s = OW'(q_l_c[NCELL]);
    q_r_s = OW'(q_r_c[NCELL]);
    sp_l = ctl_c[NCELL].left_neg ? -q_l_s : q_l_s;
    sp_r = ctl_c[NCELL].right_neg ? -q_r_s : q_r_s;
  end

  assign push = ctl_c[NCELL].valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        left_speed <= skid_left;
        right_speed <= skid_right;
        motion_class <= skid_cls;
      end else begin
        left_speed <= sp_l[SPEED_W-1:0];
        right_speed <= sp_r[SPEED_W-1:0];
        motion_class <= ctl_c[NCELL].cls;
      end
    end else if (push) begin
      skid_left <= sp_l[SPEED_W-1:0];
      skid_right <= sp_r[SPEED_W-1:0];
      skid_cls <= ctl_c[NCELL].cls;
    end
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a beat while the output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid beat not moved to the output");

  a_stall_catches: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && push |=> skid_valid)
    else $error("beat lost while the receiver stalls");

  a_quotient_bound: assert property (@(posedge clk) disable iff (rst)
    ctl_c[NCELL].valid |-> (q_l_c[NCELL] <= Q_ONE) && (q_r_c[NCELL] <= Q_ONE))
    else $error("scaled speed above one");
`endif

endmodule

/* tb/sv/ddm_wheel_checker.sv */
// checker for the differential drive mixer: predicts wheel speeds and motion class, compares beats
`timescale 1ns / 1ps
module ddm_wheel_checker import ddm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [2:0]                req_type,
  input  logic signed [CMD_W-1:0]   linear_cmd,
  input  logic signed [CMD_W-1:0]   angular_cmd,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [SPEED_W-1:0] left_speed,
  input  logic signed [SPEED_W-1:0] right_speed,
  input  logic [2:0]                motion_class,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [THR_W-1:0]          cfg_data,
  output int                        mismatch_count,
  output int                        wheels_pending
);

  typedef struct packed {
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
    motion_t                   cls;
  } wheel_cmd_t;

  wheel_cmd_t       expected_wheels [$];
  wheel_cmd_t       oldest;
  logic [THR_W-1:0] still_thr;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp_unit(input longint v, input longint one);
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic wheel_cmd_t mix_speeds(input logic [2:0] req,
                                            input logic signed [CMD_W-1:0] lc,
                                            input logic signed [CMD_W-1:0] ac,
                                            input logic [THR_W-1:0] thr);
    longint     one;
    longint     lin;
    longint     ang;
    longint     lft;
    longint     rgt;
    longint     peak;
    logic       has_lin;
    logic       has_ang;
    wheel_cmd_t r;
    one = longint'(1) << FRAC_BITS;
    lin = 0;
    ang = 0;
    r = '0;
    r.cls = MC_STOPPED;
    case (req)
      REQ_DRIVE: begin
        lin = lc;
        ang = ac;
      end
      REQ_FORWARD:      lin = magnitude(lc);
      REQ_BACKWARD:     lin = -magnitude(lc);
      REQ_ROTATE_LEFT:  ang = -magnitude(lc);
      REQ_ROTATE_RIGHT: ang = magnitude(lc);
      // stop and the unused codes
      default: return r;
    endcase
    lin = clamp_unit(lin, one);
    ang = clamp_unit(ang, one);
    lft = lin + ang;
    rgt = lin - ang;
    peak = (magnitude(lft) > magnitude(rgt)) ? magnitude(lft) : magnitude(rgt);
    if (peak > one) begin
      // integer division truncates toward zero
      lft = (lft * one) / peak;
      rgt = (rgt * one) / peak;
    end
    has_lin = magnitude(lin) > longint'(thr);
    has_ang = magnitude(ang) > longint'(thr);
    if (!has_lin && !has_ang) r.cls = MC_STOPPED;
    else if (has_lin && has_ang) r.cls = MC_CURVE;
    else if (has_lin) r.cls = (lin > 0) ? MC_FORWARD : MC_BACKWARD;
    else r.cls = (ang < 0) ? MC_ROTATE_LEFT : MC_ROTATE_RIGHT;
    r.left = lft[SPEED_W-1:0];
    r.right = rgt[SPEED_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t error: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      still_thr = THR_RESET;
      expected_wheels.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) still_thr = cfg_data;
      // output beat is checked before this edge's input beat is queued
      if (out_valid && out_ready) begin
        if (expected_wheels.size() == 0) begin
          report_mismatch($sformatf("output beat with nothing expected: %0d %0d %0d",
                                    left_speed, right_speed, motion_class));
        end else begin
          oldest = expected_wheels.pop_front();
          if (left_speed !== oldest.left)
            report_mismatch($sformatf("left_speed got %0d expected %0d",
                                      left_speed, oldest.left));
          if (right_speed !== oldest.right)
            report_mismatch($sformatf("right_speed got %0d expected %0d",
                                      right_speed, oldest.right));
          if (motion_class !== oldest.cls)
            report_mismatch($sformatf("motion_class got %0d expected %0d",
                                      motion_class, oldest.cls));
        end
      end
      if (in_valid && in_ready)
        expected_wheels.push_back(mix_speeds(req_type, linear_cmd, angular_cmd, still_thr));
    end
    wheels_pending = expected_wheels.size();
  end

endmodule

/* tb/sv/differential_drive_mixer_tb.sv */
// testbench top for the differential drive mixer: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module differential_drive_mixer_tb;
  import ddm_pkg::*;

  localparam int FRAC_BITS = 14;
  localparam int LATENCY = FRAC_BITS + 4;
  localparam int PHASE_ITEMS = 275;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [2:0]                req_type = '0;
  logic signed [CMD_W-1:0]   linear_cmd = '0;
  logic signed [CMD_W-1:0]   angular_cmd = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic [2:0]                motion_class;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [THR_W-1:0]          cfg_data = '0;

  int mismatch_count;
  int wheels_pending;
  int cycle_count = 0;
  int commands_sent = 0;
  int thr_settings = 1;
  int holds_done = 0;
  int burst_left = 0;
  int thr_now = THR_RESET;
  bit hold_request = 1'b0;

  differential_drive_mixer #(
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .linear_cmd   (linear_cmd),
    .angular_cmd  (angular_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_speed   (left_speed),
    .right_speed  (right_speed),
    .motion_class (motion_class),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  ddm_wheel_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .linear_cmd     (linear_cmd),
    .angular_cmd    (angular_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_speed     (left_speed),
    .right_speed    (right_speed),
    .motion_class   (motion_class),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .wheels_pending (wheels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               wheels_pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: segments of random modes, plus long hold-offs on request
  initial begin : receiver
    int mode;
    int span;
    int beat_no;
    beat_no = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 120);
      repeat (span) begin
        @(posedge clk);
        beat_no++;
        if (hold_request) begin
          hold_request = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          out_ready <= 1'b1;
          holds_done++;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (beat_no % 4) != 0;
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  function automatic logic signed [CMD_W-1:0] pick_cmd(input int thr);
    int sel;
    int v;
    sel = $urandom_range(0, 7);
    case (sel)
      0, 1, 2: return 16'($urandom);
      3: v = thr + int'($urandom_range(0, 4)) - 2;
      4: v = 16384 + int'($urandom_range(0, 64)) - 32;
      5: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sd0;
          3: return 16'sd16384;
          default: return -16'sd16384;
        endcase
      end
      6: v = $urandom_range(0, 64);
      default: v = $urandom_range(0, 16384);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v[CMD_W-1:0];
  endfunction

  // offer one command beat, with bursts and gaps on the sender side
  task automatic offer(input logic [2:0] req, input logic signed [CMD_W-1:0] lin,
                       input logic signed [CMD_W-1:0] ang);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= req;
    linear_cmd <= lin;
    angular_cmd <= ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    commands_sent++;
  endtask

  task automatic random_command();
    int r;
    logic [2:0] req;
    logic signed [CMD_W-1:0] lin;
    logic signed [CMD_W-1:0] ang;
    r = $urandom_range(0, 19);
    lin = pick_cmd(thr_now);
    ang = pick_cmd(thr_now);
    if (r < 10) begin
      req = REQ_DRIVE;
      if ($urandom_range(0, 5) == 0) lin = '0;
      else if ($urandom_range(0, 5) == 0) ang = '0;
    end else if (r < 12) req = REQ_FORWARD;
    else if (r < 14) req = REQ_BACKWARD;
    else if (r < 16) req = REQ_ROTATE_LEFT;
    else if (r < 18) req = REQ_ROTATE_RIGHT;
    else if (r == 18) req = REQ_STOP;
    else req = ($urandom_range(0, 1) == 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
    offer(req, lin, ang);
  endtask

  // written only once the pipeline has drained
  task automatic set_threshold(input logic [THR_W-1:0] v);
    in_valid <= 1'b0;
    @(negedge clk);
    while (wheels_pending != 0) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_now = v;
    thr_settings++;
  endtask

  initial begin : stimulus
    int thr_plan [6];
    thr_plan[0] = 0;
    thr_plan[1] = 1024;
    thr_plan[2] = 2047;
    thr_plan[3] = 1;
    thr_plan[4] = $urandom_range(2, 1023);
    thr_plan[5] = 16;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats at the reset threshold
    offer(REQ_DRIVE, 16'sd0, 16'sd0);
    offer(REQ_DRIVE, 16'sd16384, 16'sd0);
    offer(REQ_DRIVE, -16'sd16384, 16'sd0);
    offer(REQ_DRIVE, 16'sd0, -16'sd16384);
    offer(REQ_DRIVE, 16'sd0, 16'sd16384);
    offer(REQ_DRIVE, 16'sh7fff, 16'sh7fff);
    offer(REQ_DRIVE, 16'sh8000, 16'sh8000);
    offer(REQ_DRIVE, 16'sh7fff, 16'sh8000);
    offer(REQ_DRIVE, 16'sd12000, 16'sd8000);
    offer(REQ_DRIVE, -16'sd9000, 16'sd13001);
    // at and just above the still threshold, both signs
    offer(REQ_DRIVE, 16'sd16, 16'sd16);
    offer(REQ_DRIVE, 16'sd17, 16'sd0);
    offer(REQ_DRIVE, -16'sd17, 16'sd0);
    offer(REQ_DRIVE, 16'sd0, 16'sd17);
    offer(REQ_DRIVE, 16'sd0, -16'sd17);
    offer(REQ_DRIVE, 16'sd17, -16'sd17);
    // wrappers take the magnitude, most negative value included
    offer(REQ_FORWARD, 16'sh8000, 16'sd77);
    offer(REQ_FORWARD, 16'sd5000, 16'sd0);
    offer(REQ_BACKWARD, 16'sh7fff, -16'sd300);
    offer(REQ_BACKWARD, -16'sd5000, 16'sd0);
    offer(REQ_ROTATE_LEFT, 16'sd5000, 16'sd9999);
    offer(REQ_ROTATE_RIGHT, -16'sd5000, 16'sd0);
    offer(REQ_STOP, 16'sd1234, -16'sd4321);
    offer(REQ_UNUSED_LO, 16'sh7fff, 16'sh7fff);
    offer(REQ_UNUSED_HI, 16'sh8000, 16'sd200);

    repeat (PHASE_ITEMS) random_command();
    for (int p = 0; p < 6; p++) begin
      set_threshold(thr_plan[p][THR_W-1:0]);
      // the sender keeps offering while the receiver holds off
      if (p == 1 || p == 4) hold_request = 1'b1;
      repeat (PHASE_ITEMS) random_command();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (wheels_pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d commands across %0d threshold settings (0 to 2047)", commands_sent,
             thr_settings);
    $display("all request codes, clamp and normalize cases, %0d long output hold-offs",
             holds_done);
    if (mismatch_count == 0 && wheels_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
